@@ hw/rtl/tmx_pkg.sv @@
// ----------------------------------------------------------------------------
// tmx_pkg
// Types and constants shared by the two-channel square tone mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmx_pkg;

    // input item kinds
    localparam logic [2:0] KIND_SAMPLE   = 3'd0;
    localparam logic [2:0] KIND_SET_CH0  = 3'd1;
    localparam logic [2:0] KIND_SET_CH2  = 3'd2;
    localparam logic [2:0] KIND_GATE_ON  = 3'd3;
    localparam logic [2:0] KIND_GATE_OFF = 3'd4;

    // register indexes on the config port
    localparam logic [1:0] REG_SAMPLE_RATE    = 2'd0;
    localparam logic [1:0] REG_TICK_INCREMENT = 2'd1;
    localparam logic [1:0] REG_PULSE_MODE     = 2'd2;
    localparam logic [1:0] REG_PULSE_WIDTH    = 2'd3;

    localparam logic [15:0] SAMPLE_RATE_RST = 16'd22050;
    localparam logic [6:0]  PULSE_WIDTH_RST = 7'd50;

    localparam logic [15:0] MUTE_DIVISOR = 16'd40;
    localparam logic [16:0] PW_SCALE     = 17'd655;
    localparam logic [16:0] TICK_WRAP    = 17'h04000;
    localparam logic [4:0]  DIV_LAST     = 5'd31;

    localparam longint unsigned LEVEL_MAG = 64'd32767;
    localparam longint unsigned MIX_DIV   = 64'd196605;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] divisor;
    } tmx_in_t;

    typedef struct packed {
        logic [7:0] sample;
        logic       tick_interrupt;
    } tmx_out_t;

    typedef struct packed {
        logic [15:0] sample_rate;
        logic [15:0] tick_increment;
        logic        pulse_mode;
        logic [6:0]  pulse_width;
    } tmx_cfg_t;

    typedef enum logic [1:0] {
        LVL_ZERO = 2'd0,
        LVL_HIGH = 2'd1,
        LVL_LOW  = 2'd2
    } tmx_level_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } tmx_alu_op_t;

    typedef struct packed {
        tmx_alu_op_t op;
        logic [16:0] a;
        logic [16:0] b;
    } tmx_alu_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PH0,
        ST_TICK,
        ST_WRAP,
        ST_PH2,
        ST_CMP
    } tmx_state_t;

    // mix level for combined index k = v0 + 2*v2 + 3 (in level units)
    function automatic logic [7:0] mix_calc(input int unsigned k, input int unsigned smax);
        longint unsigned p;
        p = longint'(k) * LEVEL_MAG * longint'(smax);
        return 8'(p / MIX_DIV);
    endfunction

    function automatic logic [2:0] mix_index(input tmx_level_t l0, input tmx_level_t l2);
        int k;
        k = 3;
        case (l0)
            LVL_HIGH: k = k + 1;
            LVL_LOW:  k = k - 1;
            default:  k = k;
        endcase
        case (l2)
            LVL_HIGH: k = k + 2;
            LVL_LOW:  k = k - 2;
            default:  k = k;
        endcase
        return 3'(k);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/two_channel_square_tone_mixer.sv @@
// ----------------------------------------------------------------------------
// two_channel_square_tone_mixer
// Two timer tone channels with tick interrupt flag, mixed to 8-bit samples.
//
// Input channel s_*: one item per transfer (sample, set ch0/ch2 divisor,
// gate ch2 on/off). Result channel m_*: one result per sample item only.
// Config via APB port, registers at byte address 4*i, pready tied high.
// Items are handled one at a time by a sequencer around one shared
// 17-bit add/subtract unit; s_ready is low while an item is in work.
// Sample item steps: phase 0, tick add and tick wrap only on carry, phase 2,
// threshold compare, one ALU pass each. Divisor item: one quotient bit per
// cycle over 32 bits; zero divisor and the ch2 mute divisor, and gate items,
// are handled in the idle state with no ALU pass.
// One output register holds a finished result; the next item is taken
// while it waits. If the receiver stalls, a sample waits in its last step
// until the register frees.
// Reset: all phases, steps, levels and the gate clear, registers return
// to their defaults, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module two_channel_square_tone_mixer #(
    parameter int unsigned SAMPLE_MAX = 255
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [3:0]              paddr,
    input  wire [31:0]             pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  var tmx_pkg::tmx_in_t   s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output tmx_pkg::tmx_out_t      m_data
);
    import tmx_pkg::*;

    tmx_cfg_t   cfg_reg, cfg_next;
    logic       m_valid_reg, m_valid_next;
    tmx_out_t   m_data_reg, m_data_next;
    logic       out_free;
    logic       res_valid;
    tmx_out_t   res_data;
    logic       wr_en;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_SAMPLE_RATE:    cfg_next.sample_rate    = pwdata[15:0];
                REG_TICK_INCREMENT: cfg_next.tick_increment = pwdata[15:0];
                REG_PULSE_MODE:     cfg_next.pulse_mode     = pwdata[0];
                REG_PULSE_WIDTH:    cfg_next.pulse_width    = pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SAMPLE_RATE:    prdata = {16'h0000, cfg_reg.sample_rate};
            REG_TICK_INCREMENT: prdata = {16'h0000, cfg_reg.tick_increment};
            REG_PULSE_MODE:     prdata = {31'h0, cfg_reg.pulse_mode};
            REG_PULSE_WIDTH:    prdata = {25'h0, cfg_reg.pulse_width};
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '{sample_rate: SAMPLE_RATE_RST, tick_increment: '0,
                             pulse_mode: 1'b0, pulse_width: PULSE_WIDTH_RST};
            m_valid_reg <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    tmx_core #(
        .SAMPLE_MAX (SAMPLE_MAX)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

`ifndef NO_ASSERTIONS
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result pending after reset");

    a_emit_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result written over an untaken transfer");

    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.kind == KIND_SAMPLE) |=> !s_ready)
        else $error("ready right after a sample transfer");

    a_no_emit_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid)
        else $error("result produced while idle");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tmx_alu.sv @@
// ----------------------------------------------------------------------------
// tmx_alu
// Shared 17-bit add/subtract unit; bit 17 of the result is carry or borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module tmx_alu (
    input  var tmx_pkg::tmx_alu_req_t req,
    output logic [17:0]               res
);
    import tmx_pkg::*;

    always_comb begin
        case (req.op)
            ALU_ADD: res = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: res = {1'b0, req.a} - {1'b0, req.b};
            default: res = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/tmx_core.sv @@
// ----------------------------------------------------------------------------
// tmx_core
// Sequencer and tone state; runs divisions and sample updates on the ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module tmx_core #(
    parameter int unsigned SAMPLE_MAX = 255
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  var tmx_pkg::tmx_cfg_t  cfg,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  var tmx_pkg::tmx_in_t   in_data,
    input  wire                    out_free,
    output logic                   res_valid,
    output tmx_pkg::tmx_out_t      res_data
);
    import tmx_pkg::*;

    localparam logic [7:0] MIX_TABLE [0:6] = '{
        mix_calc(0, SAMPLE_MAX), mix_calc(1, SAMPLE_MAX), mix_calc(2, SAMPLE_MAX),
        mix_calc(3, SAMPLE_MAX), mix_calc(4, SAMPLE_MAX), mix_calc(5, SAMPLE_MAX),
        mix_calc(6, SAMPLE_MAX)
    };

    tmx_state_t  state_reg, state_next;
    logic [15:0] phase0_reg, phase0_next;
    logic [15:0] phase2_reg, phase2_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] step0_reg, step0_next;
    logic [15:0] step2_reg, step2_next;
    tmx_level_t  level0_reg, level0_next;
    tmx_level_t  level2_reg, level2_next;
    logic        gate2_reg, gate2_next;
    logic        irq_reg, irq_next;
    logic        dest_reg, dest_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] dq_reg, dq_next;
    logic [15:0] div_reg, div_next;

    tmx_alu_req_t alu_req;
    logic [17:0]  alu_res;
    logic [16:0]  thr;
    logic         qbit;

    tmx_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign thr  = 17'(cfg.pulse_width) * PW_SCALE;
    assign qbit = ~alu_res[17];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase0_reg <= '0;
            phase2_reg <= '0;
            tick_reg   <= '0;
            step0_reg  <= '0;
            step2_reg  <= '0;
            level0_reg <= LVL_ZERO;
            level2_reg <= LVL_ZERO;
            gate2_reg  <= 1'b0;
            irq_reg    <= 1'b0;
            dest_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            phase0_reg <= phase0_next;
            phase2_reg <= phase2_next;
            tick_reg   <= tick_next;
            step0_reg  <= step0_next;
            step2_reg  <= step2_next;
            level0_reg <= level0_next;
            level2_reg <= level2_next;
            gate2_reg  <= gate2_next;
            irq_reg    <= irq_next;
            dest_reg   <= dest_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        div_reg <= div_next;
    end

    always_comb begin
        state_next  = state_reg;
        phase0_next = phase0_reg;
        phase2_next = phase2_reg;
        tick_next   = tick_reg;
        step0_next  = step0_reg;
        step2_next  = step2_reg;
        level0_next = level0_reg;
        level2_next = level2_reg;
        gate2_next  = gate2_reg;
        irq_next    = irq_reg;
        dest_next   = dest_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dq_next     = dq_reg;
        div_next    = div_reg;
        alu_req     = '{op: ALU_ADD, a: '0, b: '0};
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        res_data    = '0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_data.kind)
                        KIND_SAMPLE: begin
                            irq_next   = 1'b0;
                            state_next = ST_PH0;
                        end
                        KIND_SET_CH0, KIND_SET_CH2: begin
                            dest_next = (in_data.kind == KIND_SET_CH2);
                            if (in_data.kind == KIND_SET_CH2
                                && in_data.divisor == MUTE_DIVISOR) begin
                                step2_next = '0;
                            end else if (in_data.divisor == '0) begin
                                if (in_data.kind == KIND_SET_CH2) begin
                                    step2_next = cfg.sample_rate;
                                end else begin
                                    step0_next = cfg.sample_rate;
                                end
                            end else begin
                                div_next   = in_data.divisor;
                                dq_next    = {cfg.sample_rate, 16'h0000};
                                rem_next   = '0;
                                cnt_next   = '0;
                                state_next = ST_DIV;
                            end
                        end
                        KIND_GATE_ON:  gate2_next = 1'b1;
                        KIND_GATE_OFF: gate2_next = 1'b0;
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                alu_req = '{op: ALU_SUB, a: {rem_reg, dq_reg[31]}, b: {1'b0, div_reg}};
                rem_next = qbit ? alu_res[15:0] : {rem_reg[14:0], dq_reg[31]};
                dq_next  = {dq_reg[30:0], qbit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST) begin
                    if (dest_reg) begin
                        step2_next = {dq_reg[14:0], qbit};
                    end else begin
                        step0_next = {dq_reg[14:0], qbit};
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_PH0: begin
                alu_req = '{op: ALU_ADD, a: {1'b0, phase0_reg}, b: {1'b0, step0_reg}};
                phase0_next = alu_res[15:0];
                state_next  = alu_res[16] ? ST_TICK : ST_PH2;
            end
            ST_TICK: begin
                alu_req = '{op: ALU_ADD, a: {1'b0, tick_reg}, b: {1'b0, cfg.tick_increment}};
                tick_next  = alu_res[15:0];
                state_next = alu_res[16] ? ST_WRAP : ST_PH2;
            end
            ST_WRAP: begin
                alu_req    = '{op: ALU_SUB, a: {1'b0, tick_reg}, b: TICK_WRAP};
                tick_next  = alu_res[15:0];
                irq_next   = 1'b1;
                state_next = ST_PH2;
            end
            ST_PH2: begin
                alu_req = '{op: ALU_ADD, a: {1'b0, phase2_reg}, b: {1'b0, step2_reg}};
                phase2_next = alu_res[15:0];
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                // borrow of thr - phase0 means phase0 above threshold
                alu_req = '{op: ALU_SUB, a: thr, b: {1'b0, phase0_reg}};
                if (out_free) begin
                    if (cfg.pulse_mode) begin
                        level0_next = alu_res[17] ? LVL_LOW : LVL_HIGH;
                    end
                    if (step2_reg != '0 && gate2_reg) begin
                        level2_next = phase2_reg[15] ? LVL_LOW : LVL_HIGH;
                    end
                    res_valid               = 1'b1;
                    res_data.sample         = MIX_TABLE[mix_index(level0_next, level2_next)];
                    res_data.tick_interrupt = irq_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire
